[hw/rtl/mltq_pkg.sv]
`timescale 1ns / 1ps
package mltq_pkg;

    localparam int POINTS_DEF = 65536;
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] slope;
        logic signed [47:0] intercept;
        logic [15:0]        point_index;
    } mltq_in_t;

    typedef struct packed {
        logic signed [48:0] max_value;
        logic               found;
    } mltq_out_t;

    // item travelling down the chain, one level per cell
    typedef struct packed {
        logic               active;
        logic               command;
        logic signed [31:0] slope;
        logic signed [47:0] intercept;
        logic [20:0]        lo;
        logic [20:0]        hi;
        logic [20:0]        x;
        logic [19:0]        node;
        logic               any;
        logic signed [69:0] best;
    } mltq_walk_t;

    function automatic logic signed [69:0] line_at(input logic signed [31:0] k,
        input logic signed [47:0] b, input logic [20:0] i);
        logic signed [22:0] xs;
        logic signed [54:0] prod;
        begin
            xs = $signed({2'b00, i}) + 23'sd1;
            prod = 55'(k) * 55'(xs);
            line_at = 70'(prod) + 70'(b);
        end
    endfunction

endpackage

[hw/rtl/mltq_level.sv]
`timescale 1ns / 1ps
// one tree level: node memory of this depth plus the compare logic
module mltq_level
    import mltq_pkg::*;
#(
    parameter int LEVEL = 0,
    parameter int AW = 1
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic          clr,
    input  logic [AW-1:0] clr_addr,
    input  mltq_walk_t    walk_in,
    output mltq_walk_t    walk_out
);
    localparam int IW = (LEVEL > 0) ? LEVEL : 1;
    localparam int DEPTH = 1 << IW;

    logic [31:0] slope_mem [DEPTH];
    logic [47:0] icpt_mem [DEPTH];
    logic        valid_mem [DEPTH];

    logic [1:0] phase_reg;
    mltq_walk_t w_reg;
    logic [IW-1:0] idx_reg;
    logic signed [31:0] ms_reg;
    logic signed [47:0] mb_reg;
    logic mv_reg;
    mltq_walk_t walk_reg;

    logic [IW-1:0] idx_w;
    logic [IW-1:0] clr_idx;
    logic [20:0] mid;
    logic nv;
    logic signed [31:0] kl;
    logic signed [47:0] bl;
    logic signed [69:0] s_mid, n_mid, s_lo, n_lo, s_hi, n_hi, s_x;
    logic swap;
    logic lo_win;
    logic hi_win;
    mltq_walk_t nxt;

    always_comb
    begin
        idx_w = IW'(walk_in.node);
        clr_idx = IW'(clr_addr);
    end

    // phase 0 idle, 1 read issued, 2 result out
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ms_reg <= slope_mem[idx_w];
            mb_reg <= icpt_mem[idx_w];
            mv_reg <= valid_mem[idx_w];
        end
        if (clr)
            valid_mem[clr_idx] <= 1'b0;
        else if (phase_reg == 2'd1 && w_reg.active && w_reg.command == CMD_INSERT)
        begin
            valid_mem[idx_reg] <= 1'b1;
            if (!nv || swap)
            begin
                slope_mem[idx_reg] <= w_reg.slope;
                icpt_mem[idx_reg] <= w_reg.intercept;
            end
        end
    end

    always_comb
    begin
        mid = 21'((22'(w_reg.lo) + 22'(w_reg.hi)) >> 1);
        nv = mv_reg;
        // stored and new line values, all taken side by side
        s_mid = line_at(ms_reg, mb_reg, mid);
        n_mid = line_at(w_reg.slope, w_reg.intercept, mid);
        s_lo = line_at(ms_reg, mb_reg, w_reg.lo);
        n_lo = line_at(w_reg.slope, w_reg.intercept, w_reg.lo);
        s_hi = line_at(ms_reg, mb_reg, w_reg.hi);
        n_hi = line_at(w_reg.slope, w_reg.intercept, w_reg.hi);
        s_x = line_at(ms_reg, mb_reg, w_reg.x);
        swap = s_mid < n_mid;
        kl = swap ? ms_reg : w_reg.slope;
        bl = swap ? mb_reg : w_reg.intercept;
        // loser strictly above the kept line at an end of the range
        lo_win = swap ? (n_lo < s_lo) : (s_lo < n_lo);
        hi_win = swap ? (n_hi < s_hi) : (s_hi < n_hi);
        nxt = w_reg;
        if (w_reg.command == CMD_INSERT)
        begin
            nxt.slope = kl;
            nxt.intercept = bl;
            if (!w_reg.active || !nv)
                nxt.active = 1'b0;
            else if (lo_win)
            begin
                nxt.hi = mid;
                nxt.node = {w_reg.node[18:0], 1'b0};
            end
            else if (hi_win)
            begin
                nxt.lo = mid + 21'd1;
                nxt.node = {w_reg.node[18:0], 1'b1};
            end
            else
                nxt.active = 1'b0;
        end
        else
        begin
            if (w_reg.active && nv)
            begin
                if (!w_reg.any || s_x > w_reg.best)
                    nxt.best = s_x;
                nxt.any = 1'b1;
            end
            if (w_reg.x <= mid)
            begin
                nxt.hi = mid;
                nxt.node = {w_reg.node[18:0], 1'b0};
            end
            else
            begin
                nxt.lo = mid + 21'd1;
                nxt.node = {w_reg.node[18:0], 1'b1};
            end
            if (w_reg.lo == w_reg.hi)
                nxt.active = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else
        begin
            if (go)
                phase_reg <= 2'd1;
            else if (phase_reg == 2'd1)
                phase_reg <= 2'd2;
            else
                phase_reg <= 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            w_reg <= walk_in;
            idx_reg <= idx_w;
        end
        if (phase_reg == 2'd1)
            walk_reg <= nxt;
    end

    assign walk_out = walk_reg;
endmodule

[hw/rtl/max_line_tree_insert_query_unit.sv]
`timescale 1ns / 1ps
// max line tree, insert and query
// input channel in_valid/in_stall carries mltq_in_t beats: command 0
// inserts line slope*x+intercept, command 1 queries the maximum at
// x = point_index+1. each query yields one out beat (max_value, found),
// inserts yield none.
// the tree is a chain of cells, one per level, each owning that level's
// node memories (read registered, written back in the following cycle). in
// each cell an item reads the node, then compares and registers its walk
// for the next cell. one item is in flight at a time; the next beat is
// taken once the walk has ended and busy has cleared.
// after reset a clearing pass steps over all 2**clog2(POINTS) node slots
// (65536 at the default) and empties every node; in_stall stays high
// meanwhile.
// the result waits in an output register while out_stall is high; if the
// next query finishes before that beat has left, it holds in the last
// cell and the input stays stalled until the register frees up.
// queries with point_index of POINTS or more return found 0, value 0.
module max_line_tree_insert_query_unit
    import mltq_pkg::*;
#(
    parameter int POINTS = POINTS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  mltq_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output mltq_out_t out_data
);
    localparam int AW = $clog2(POINTS);
    localparam int LEVELS = AW + 1;
    localparam int CYC = 2 * LEVELS;
    localparam int CW = $clog2(CYC + 2);

    logic busy_reg;
    logic [CW-1:0] cnt_reg;
    logic ovalid_reg;
    mltq_out_t odata_reg;
    logic is_query_reg;
    logic clr_reg;
    logic [AW-1:0] clr_addr_reg;
    mltq_walk_t w0;
    mltq_walk_t chain [LEVELS+1];
    logic [LEVELS-1:0] go;
    logic accept;
    logic finish;
    logic signed [69:0] best;
    logic signed [48:0] sat;

    assign in_stall = busy_reg || clr_reg;
    assign accept = in_valid && !in_stall;
    // walk done and the output register free or emptied this cycle
    assign finish = busy_reg && cnt_reg == CW'(CYC) && (!ovalid_reg || !out_stall);

    always_comb
    begin
        w0 = '0;
        w0.command = in_data.command;
        w0.slope = in_data.slope;
        w0.intercept = in_data.intercept;
        w0.lo = '0;
        w0.hi = 21'(POINTS - 1);
        w0.x = 21'(in_data.point_index);
        // out of range queries meet no node
        w0.active = !(in_data.command == CMD_QUERY &&
                      22'(in_data.point_index) > 22'(POINTS - 1));
    end

    assign chain[0] = w0;

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++)
        begin : g_lvl
            // cell g starts once the cell before it has registered its walk
            assign go[g] = (g == 0) ? accept : (busy_reg && cnt_reg == CW'(2 * g));
            mltq_level #(.LEVEL(g), .AW(AW)) u_lvl (
                .clk(clk), .rst_n(rst_n), .go(go[g]),
                .clr(clr_reg), .clr_addr(clr_addr_reg),
                .walk_in(chain[g]), .walk_out(chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        best = chain[LEVELS].best;
        if (!chain[LEVELS].any)
            sat = '0;
        else if (best > 70'sd281474976710655)
            sat = 49'sh0_FFFF_FFFF_FFFF;
        else if (best < -70'sd281474976710656)
            sat = 49'sh1_0000_0000_0000;
        else
            sat = best[48:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            ovalid_reg <= 1'b0;
            clr_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (finish)
                busy_reg <= 1'b0;
            else if (busy_reg && cnt_reg != CW'(CYC))
                cnt_reg <= cnt_reg + 1'b1;
            ovalid_reg <= (finish && is_query_reg) || (ovalid_reg && out_stall);
            // clearing pass over every node slot after reset
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                    clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            is_query_reg <= in_data.command;
        if (finish)
        begin
            odata_reg.max_value <= sat;
            odata_reg.found <= chain[LEVELS].any;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;
endmodule
